>>> rtl/line_position_pd_motor_drive_macros.svh
// Assertion macros shared by the checker of the line position PD motor drive.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef LINE_POSITION_PD_MOTOR_DRIVE_MACROS_SVH
`define LINE_POSITION_PD_MOTOR_DRIVE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lpd_checker: same-cycle property violated");

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lpd_checker: next-cycle property violated");

`endif

>>> rtl/lpd_pkg.sv
// Package for the line position PD motor drive: widths, sensor weights,
// register indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package lpd_pkg;

	// Fixed field widths.
	localparam int SENSOR_W  = 12;
	localparam int CFG_IDX_W = 2;
	localparam int GAIN_W    = 8;
	localparam int DUTY_W    = 8;
	localparam int ERR_W     = 7;

	// Internal datapath widths.
	localparam int WT_SLOTS  = 16;
	localparam int WT_IDX_W  = 4;
	localparam int WEIGHT_W  = 7;
	localparam int SUM_W     = 9;
	localparam int CNT_W     = 4;
	localparam int DVD_W     = 8;
	localparam int REM_W     = 4;
	localparam int DIV_STEPS = 8;
	localparam int STEP_W    = 3;
	localparam int DIFF_W    = 8;
	localparam int PROD_W    = 17;
	localparam int ALU_W     = 18;

	typedef logic signed [WEIGHT_W-1:0] weight_t;

	// Position weight of each sensor; slots past the twelfth sensor are unused.
	localparam weight_t WEIGHT_TAB [WT_SLOTS] = '{
		-7'sd60, -7'sd50, -7'sd30, -7'sd20, -7'sd10, 7'sd0, 7'sd0, 7'sd10,
		7'sd20, 7'sd30, 7'sd50, 7'sd60, 7'sd0, 7'sd0, 7'sd0, 7'sd0
	};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP   = 2'd0,
		REG_KD   = 2'd1,
		REG_BASE = 2'd2
	} reg_idx_t;

	// Register values after reset.
	localparam logic [GAIN_W-1:0] KP_RST   = 8'd3;
	localparam logic [GAIN_W-1:0] KD_RST   = 8'd0;
	localparam logic [GAIN_W-1:0] BASE_RST = 8'd80;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_SIGN,
		ST_DIFF,
		ST_MULD,
		ST_SUMU,
		ST_LADD,
		ST_LCLP,
		ST_RADD,
		ST_RCLP,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/line_position_pd_motor_drive.sv
// Line position PD motor drive: weighted-centroid line position and PD steering.
// Depends on lpd_pkg for widths, the sensor weight table and the state type.
`timescale 1ns / 1ps

// One beat of sensor bits yields one beat of motor commands. The block takes a
// beat only when idle and then works on it alone. A sequencer drives one shared
// 18-bit adder: it scans one sensor per cycle, runs an eight-step restoring
// divide for the average, then forms the PD sum and both drives through the
// same adder, with one 9x8 multiplier used once for each gain. When no sensor
// sees the line, the divide and the PD steps are skipped. A finished result
// sits in an output register, so the next beat may be accepted while it waits
// to be taken.
// Configuration writes take effect at once and belong in idle periods.
module line_position_pd_motor_drive #(
	parameter int NUM_SENSORS = 12,
	parameter int DUTY_MAX    = 255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpd_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [lpd_pkg::GAIN_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lpd_pkg::SENSOR_W-1:0]        sensor_bits,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lpd_pkg::DUTY_W-1:0]          left_duty,
	output logic                                left_reverse,
	output logic [lpd_pkg::DUTY_W-1:0]          right_duty,
	output logic                                right_reverse,
	output logic signed [lpd_pkg::ERR_W-1:0]    position_error,
	output logic                                line_lost
);
	import lpd_pkg::*;

	localparam int SCAN_N = (NUM_SENSORS < SENSOR_W) ? NUM_SENSORS : SENSOR_W;
	localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCAN_N - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);
	localparam logic signed [ALU_W-1:0] DMAX = ALU_W'(DUTY_MAX);

	state_t state_q, state_d;

	// Configuration and persistent state.
	logic [GAIN_W-1:0]        kp_q, kd_q, base_q;
	logic signed [ERR_W-1:0]  last_q;

	// Working registers.
	logic [SENSOR_W-1:0]      sens_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [REM_W-1:0]         rem_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [ALU_W-1:0]  acc_q, prod_q, drv_q;
	logic [DUTY_W-1:0]        lduty_q, rduty_q;
	logic                     lrev_q, rrev_q, lost_q;

	// Output register.
	logic                     out_valid_q;
	logic [DUTY_W-1:0]        left_duty_q, right_duty_q;
	logic                     left_reverse_q, right_reverse_q, line_lost_q;
	logic signed [ERR_W-1:0]  position_error_q;

	// Shared arithmetic.
	logic signed [ALU_W-1:0]  alu_a, alu_b, alu_y;
	logic                     alu_sub;
	logic [GAIN_W-1:0]        mul_gain;
	logic signed [DIFF_W-1:0] mul_val;
	logic signed [PROD_W-1:0] mul_y;
	logic signed [ALU_W-1:0]  mag;
	logic [DUTY_W-1:0]        sat_duty;
	logic                     emit_free;

	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	assign mul_y = $signed({1'b0, mul_gain}) * mul_val;

	// Magnitude of the current drive, then saturation at the duty limit.
	assign mag      = drv_q[ALU_W-1] ? alu_y : drv_q;
	assign sat_duty = (mag > DMAX) ? DMAX[DUTY_W-1:0] : mag[DUTY_W-1:0];

	assign emit_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == IDX_LAST) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = (cnt_q == '0) ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_LAST) state_d = ST_SIGN;
			end
			ST_SIGN: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_MULD;
			ST_MULD: state_d = ST_SUMU;
			ST_SUMU: state_d = ST_LADD;
			ST_LADD: state_d = ST_LCLP;
			ST_LCLP: state_d = ST_RADD;
			ST_RADD: state_d = ST_RCLP;
			ST_RCLP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the shared adder and multiplier.
	always_comb begin
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		mul_gain = kp_q;
		mul_val  = DIFF_W'(err_q);
		case (state_q)
			ST_SCAN: begin
				alu_a = ALU_W'(sum_q);
				alu_b = sens_q[idx_q] ? ALU_W'(WEIGHT_TAB[WT_IDX_W'(idx_q)]) : '0;
			end
			ST_PREP: begin
				alu_b   = ALU_W'(sum_q);
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = ALU_W'({rem_q, dvd_q[DVD_W-1]});
				alu_b   = ALU_W'(cnt_q);
				alu_sub = 1'b1;
			end
			ST_SIGN: begin
				alu_b   = ALU_W'(dvd_q);
				alu_sub = 1'b1;
			end
			ST_DIFF: begin
				alu_a   = ALU_W'(err_q);
				alu_b   = ALU_W'(last_q);
				alu_sub = 1'b1;
			end
			ST_MULD: begin
				mul_gain = kd_q;
				mul_val  = diff_q;
			end
			ST_SUMU: begin
				alu_a = acc_q;
				alu_b = prod_q;
			end
			ST_LADD: begin
				alu_a = ALU_W'(base_q);
				alu_b = acc_q;
			end
			ST_RADD: begin
				alu_a   = ALU_W'(base_q);
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_LCLP, ST_RCLP: begin
				alu_b   = drv_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// Control state, configuration registers and the held error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			kp_q        <= KP_RST;
			kd_q        <= KD_RST;
			base_q      <= BASE_RST;
			last_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && emit_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_RCLP) begin
				last_q <= err_q;
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_KP:   kp_q   <= cfg_wdata;
					REG_KD:   kd_q   <= cfg_wdata;
					REG_BASE: base_q <= cfg_wdata;
					default:  kp_q   <= kp_q;
				endcase
			end
		end
	end

	// Datapath registers stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sens_q <= sensor_bits;
					idx_q  <= '0;
					sum_q  <= '0;
					cnt_q  <= '0;
				end
			end
			ST_SCAN: begin
				sum_q <= alu_y[SUM_W-1:0];
				cnt_q <= cnt_q + CNT_W'(sens_q[idx_q]);
				idx_q <= idx_q + 1'b1;
			end
			ST_PREP: begin
				// Divide the magnitude; the sign is restored afterwards.
				neg_q   <= sum_q[SUM_W-1];
				dvd_q   <= sum_q[SUM_W-1] ? alu_y[DVD_W-1:0] : sum_q[DVD_W-1:0];
				rem_q   <= '0;
				step_q  <= '0;
				lost_q  <= (cnt_q == '0);
				err_q   <= last_q;
				lduty_q <= '0;
				rduty_q <= '0;
				lrev_q  <= 1'b0;
				rrev_q  <= 1'b0;
			end
			ST_DIV: begin
				// One restoring step; quotient bits shift in behind the dividend.
				if (!alu_y[ALU_W-1]) begin
					rem_q <= alu_y[REM_W-1:0];
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				end
				step_q <= step_q + 1'b1;
			end
			ST_SIGN: begin
				err_q <= neg_q ? alu_y[ERR_W-1:0] : dvd_q[ERR_W-1:0];
			end
			ST_DIFF: begin
				diff_q <= alu_y[DIFF_W-1:0];
				acc_q  <= ALU_W'(mul_y);
			end
			ST_MULD: begin
				prod_q <= ALU_W'(mul_y);
			end
			ST_SUMU: begin
				acc_q <= alu_y;
			end
			ST_LADD, ST_RADD: begin
				drv_q <= alu_y;
			end
			ST_LCLP: begin
				lduty_q <= sat_duty;
				lrev_q  <= drv_q[ALU_W-1];
			end
			ST_RCLP: begin
				rduty_q <= sat_duty;
				rrev_q  <= drv_q[ALU_W-1];
			end
			ST_EMIT: begin
				if (emit_free) begin
					left_duty_q      <= lduty_q;
					left_reverse_q   <= lrev_q;
					right_duty_q     <= rduty_q;
					right_reverse_q  <= rrev_q;
					position_error_q <= err_q;
					line_lost_q      <= lost_q;
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign left_duty      = left_duty_q;
	assign left_reverse   = left_reverse_q;
	assign right_duty     = right_duty_q;
	assign right_reverse  = right_reverse_q;
	assign position_error = position_error_q;
	assign line_lost      = line_lost_q;

endmodule

>>> rtl/lpd_checker.sv
// Port-level checker for the line position PD motor drive, bound to the top level.
// Depends on lpd_pkg for field widths and on the shared assertion macro header.
`timescale 1ns / 1ps
`include "line_position_pd_motor_drive_macros.svh"

module lpd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [lpd_pkg::DUTY_W-1:0]       left_duty,
	input logic                             left_reverse,
	input logic [lpd_pkg::DUTY_W-1:0]       right_duty,
	input logic                             right_reverse,
	input logic signed [lpd_pkg::ERR_W-1:0] position_error,
	input logic                             line_lost
);
	import lpd_pkg::*;

	// A lost line stops both motors in the forward direction.
	`LPD_ASSERT_IMP(a_lost_stops, out_valid && line_lost, left_duty == '0 && right_duty == '0 && !left_reverse && !right_reverse)

	// The block works on one beat at a time, so it is busy right after taking one.
	`LPD_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

	// The reported error always lies within the span of the sensor weights.
	`LPD_ASSERT_IMP(a_error_span, out_valid, position_error >= -7'sd60 && position_error <= 7'sd60)

	// A result that is not taken stays put.
	`LPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_duty) && $stable(right_duty) && $stable(position_error) && $stable(line_lost))

endmodule

bind line_position_pd_motor_drive lpd_checker u_lpd_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the line position PD motor drive.
// Depends on lpd_pkg and line_position_pd_motor_drive; it predicts every command beat itself.
`timescale 1ns / 1ps

module testbench;
	import lpd_pkg::*;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 10;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int RANDOM_PHASES   = 10;
	localparam int BEATS_PER_PHASE = 153;
	localparam int STEADY_PHASE    = 5;
	localparam int IDLE_PERCENT    = 27;
	localparam int NUM_SENSE       = 12;
	localparam int DRIVE_LIMIT     = 255;

	// Index with no register behind it; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Position weight of each sensor, left to right.
	localparam int SENSOR_WEIGHT [NUM_SENSE] = '{
		-60, -50, -30, -20, -10, 0, 0, 10, 20, 30, 50, 60
	};

	typedef struct {
		logic [DUTY_W-1:0]       left_duty;
		logic                    left_reverse;
		logic [DUTY_W-1:0]       right_duty;
		logic                    right_reverse;
		logic signed [ERR_W-1:0] position_error;
		logic                    line_lost;
	} drive_cmd_t;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx        = '0;
	logic [GAIN_W-1:0]       cfg_wdata      = '0;
	logic                    in_valid       = 1'b0;
	logic                    in_ready;
	logic [SENSOR_W-1:0]     sensor_bits    = '0;
	logic                    out_valid;
	logic                    out_ready      = 1'b0;
	logic [DUTY_W-1:0]       left_duty;
	logic                    left_reverse;
	logic [DUTY_W-1:0]       right_duty;
	logic                    right_reverse;
	logic signed [ERR_W-1:0] position_error;
	logic                    line_lost;

	// Predicted commands waiting for their output beat.
	drive_cmd_t pending_cmds [$];

	// Shadow copy of the registers and of the held error.
	logic [GAIN_W-1:0] shadow_kp   = KP_RST;
	logic [GAIN_W-1:0] shadow_kd   = KD_RST;
	logic [GAIN_W-1:0] shadow_base = BASE_RST;
	logic signed [7:0] held_error  = '0;

	bit idle_enable = 1'b1;
	int fail_count  = 0;
	int cycle_count = 0;

	line_position_pd_motor_drive uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sensor_bits    (sensor_bits),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_duty      (left_duty),
		.left_reverse   (left_reverse),
		.right_duty     (right_duty),
		.right_reverse  (right_reverse),
		.position_error (position_error),
		.line_lost      (line_lost)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Saturate a signed drive and split it into magnitude and direction.
	function automatic void split_drive(input int drive, output logic [DUTY_W-1:0] duty,
			output logic reverse);
		int clipped;
		clipped = drive;
		if (clipped > DRIVE_LIMIT)
			clipped = DRIVE_LIMIT;
		else if (clipped < -DRIVE_LIMIT)
			clipped = -DRIVE_LIMIT;
		reverse = (clipped < 0);
		duty    = reverse ? DUTY_W'(-clipped) : DUTY_W'(clipped);
	endfunction

	// Centroid of the active sensors, then the PD law on both motors.
	function automatic drive_cmd_t predict_drive(input logic [SENSOR_W-1:0] bits);
		drive_cmd_t cmd;
		int         weight_sum;
		int         active;
		int         err;
		int         steer;
		weight_sum = 0;
		active     = 0;
		for (int i = 0; i < NUM_SENSE; i++) begin
			if (bits[i]) begin
				weight_sum += SENSOR_WEIGHT[i];
				active++;
			end
		end
		if (active == 0) begin
			// Line lost: stop both motors and report the held error.
			cmd.left_duty      = '0;
			cmd.left_reverse   = 1'b0;
			cmd.right_duty     = '0;
			cmd.right_reverse  = 1'b0;
			cmd.position_error = held_error[ERR_W-1:0];
			cmd.line_lost      = 1'b1;
			return cmd;
		end
		// Integer division in SystemVerilog truncates toward zero.
		err   = weight_sum / active;
		steer = int'(shadow_kp) * err + int'(shadow_kd) * (err - int'(held_error));
		held_error = 8'(err);
		split_drive(int'(shadow_base) + steer, cmd.left_duty, cmd.left_reverse);
		split_drive(int'(shadow_base) - steer, cmd.right_duty, cmd.right_reverse);
		cmd.position_error = ERR_W'(err);
		cmd.line_lost      = 1'b0;
		return cmd;
	endfunction

	// Mostly narrow runs of adjacent sensors as a real line gives, plus noise and losses.
	function automatic logic [SENSOR_W-1:0] random_sensors();
		int pick;
		int run_len;
		int run_start;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		if (pick < 65) begin
			run_len   = $urandom_range(3, 1);
			run_start = $urandom_range(NUM_SENSE - run_len, 0);
			return SENSOR_W'(((1 << run_len) - 1) << run_start);
		end
		return SENSOR_W'($urandom);
	endfunction

	// Gains and base speed lean toward the ends of their range.
	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return GAIN_W'($urandom_range(255));
		endcase
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			fail_count++;
		end
	endtask

	// Compare one output beat with the oldest prediction.
	task automatic check_result();
		drive_cmd_t want;
		if (pending_cmds.size() == 0) begin
			$error("output beat with no command expected");
			fail_count++;
			return;
		end
		want = pending_cmds.pop_front();
		check_field("left_duty", want.left_duty, left_duty);
		check_field("left_reverse", want.left_reverse, left_reverse);
		check_field("right_duty", want.right_duty, right_duty);
		check_field("right_reverse", want.right_reverse, right_reverse);
		check_field("position_error", want.position_error, position_error);
		check_field("line_lost", want.line_lost, line_lost);
	endtask

	// Output side: check accepted beats and stall at random.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_result();
			out_ready <= !idle_enable || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Offer one sensor beat and record its prediction when it is taken.
	task automatic send_sensors(input logic [SENSOR_W-1:0] bits);
		while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		sensor_bits <= bits;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_cmds.push_back(predict_drive(bits));
	endtask

	// Stop sending and wait until every predicted beat has come out.
	task automatic drain_pending();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_cmds.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_KP:   shadow_kp   = value;
			REG_KD:   shadow_kd   = value;
			REG_BASE: shadow_base = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reset gains: single sensors, all sensors, truncating averages and line loss.
	task automatic test_reset_defaults();
		send_sensors('0);
		for (int i = 0; i < NUM_SENSE; i++)
			send_sensors(SENSOR_W'(1 << i));
		send_sensors('1);
		send_sensors(12'h007);
		send_sensors(12'hE00);
		send_sensors('0);
		drain_pending();
	endtask

	// Gain and speed extremes drive both motors into saturation either way.
	task automatic test_gain_extremes();
		write_register(REG_KP, '1);
		write_register(REG_KD, '1);
		write_register(REG_BASE, '0);
		send_sensors(12'h001);
		send_sensors(12'h800);
		send_sensors('0);
		drain_pending();
		write_register(REG_KP, '0);
		write_register(REG_KD, '0);
		write_register(REG_BASE, '1);
		send_sensors(12'h060);
		send_sensors(12'h001);
		drain_pending();
		// A write to the unused index must leave every register alone.
		write_register(REG_UNUSED, '0);
		send_sensors(12'h800);
		send_sensors(12'h030);
		drain_pending();
	endtask

	// Phases of random settings, each followed by a stream of random sensor beats.
	task automatic test_random_phases();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_register(REG_KP, random_gain());
			write_register(REG_KD, random_gain());
			write_register(REG_BASE, random_gain());
			if ($urandom_range(2) == 0)
				write_register(REG_UNUSED, GAIN_W'($urandom));
			idle_enable = (phase != STEADY_PHASE);
			for (int n = 0; n < BEATS_PER_PHASE; n++)
				send_sensors(random_sensors());
			drain_pending();
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_gain_extremes();
		test_random_phases();
		drain_pending();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
